FILE: src/mxst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Maximum XOR subarray package
// Shared constants, payload structs, trie node layout and controller states.
// ----------------------------------------------------------------------------
package mxst_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NODE_DEPTH = 1 + WORD_BITS * (MAX_ITEMS + 1);
  localparam int IDX_W      = $clog2(NODE_DEPTH);
  localparam int ITEM_W     = $clog2(MAX_ITEMS + 1);
  localparam int LVL_W      = $clog2(WORD_BITS);
  localparam int LEFT_W     = $clog2(WORD_BITS + 1);

  typedef struct packed {
    logic [31:0] value;
    logic        start_new;
  } in_item_t;

  typedef struct packed {
    logic [31:0] best_xor;
    logic        overflow;
  } out_item_t;

  // A child index of zero means that the branch does not exist.
  typedef struct packed {
    logic [IDX_W-1:0] kid_one;
    logic [IDX_W-1:0] kid_zero;
  } node_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    node_t            wdata;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FRESH,
    ST_WALK,
    ST_QRY_RD,
    ST_QRY,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: src/max_xor_subarray_trie.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Maximum XOR subarray, binary trie of prefix XORs
// An element takes the insert walk and then the greedy query walk, which can
// end early; the first element after reset or a start also builds the zero
// path. A new element is taken only once the last one's result is registered.
// The single node memory port serves one trie level per cycle for the insert
// and the query. An element beyond the item limit skips both walks.
// Reset clears all control state; the node memory needs no clearing, as every
// node is written on use.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire mxst_pkg::in_item_t  in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      mxst_pkg::out_item_t out_data_o
);
  import mxst_pkg::*;

  // Control state.
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   nodes_used_q, nodes_used_d;
  logic [WORD_BITS-1:0] prefix_q, prefix_d;
  logic [WORD_BITS-1:0] best_q, best_d;
  logic [ITEM_W-1:0]  items_q, items_d;
  logic               init_q, init_d;
  logic               out_valid_q, out_valid_d;

  // Working registers of the current element.
  logic [31:0]          val_q, val_d;
  logic [WORD_BITS-1:0] key_q, key_d;
  logic [IDX_W-1:0]     at_q, at_d;
  logic [LEFT_W-1:0]    left_q, left_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic                 ovf_q, ovf_d;
  out_item_t            out_q, out_d;

  ram_req_t ram_req;
  node_t    ram_rdata;

  mxst_node_ram u_node_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // The level under inspection is one below the count of levels left.
  logic [LVL_W-1:0] lvl;
  logic             key_bit;
  logic             store_full;
  assign lvl        = LVL_W'(left_q - 1'b1);
  assign key_bit    = key_q[lvl];
  assign store_full = (nodes_used_q >= IDX_W'(NODE_DEPTH));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] flip;
    logic [IDX_W-1:0] same;
    node_t            wnode;
    logic [WORD_BITS-1:0] cand;

    state_d      = state_q;
    nodes_used_d = nodes_used_q;
    prefix_d     = prefix_q;
    best_d       = best_q;
    items_d      = items_q;
    init_d       = init_q;
    out_valid_d  = out_valid_q;
    val_d        = val_q;
    key_d        = key_q;
    at_d         = at_q;
    left_d       = left_q;
    acc_d        = acc_q;
    ovf_d        = ovf_q;
    out_d        = out_q;

    ram_req.we    = 1'b0;
    ram_req.wdata = '0;

    child = key_bit ? ram_rdata.kid_one : ram_rdata.kid_zero;
    flip  = key_bit ? ram_rdata.kid_zero : ram_rdata.kid_one;
    same  = child;
    wnode = ram_rdata;
    cand  = acc_q;

    // The result register empties as soon as the sink takes the transfer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d = in_data_i.value;
          // A start clears the trie by forgetting every allocated node.
          if (in_data_i.start_new) begin
            nodes_used_d = '0;
            prefix_d     = '0;
            best_d       = '0;
            items_d      = '0;
          end
          state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        if (nodes_used_q == '0) begin
          // Build the root and the all-zero path for the empty prefix.
          nodes_used_d = IDX_W'(1);
          at_d         = '0;
          left_d       = LEFT_W'(WORD_BITS);
          key_d        = '0;
          init_d       = 1'b1;
          state_d      = ST_FRESH;
        end else if (items_q >= ITEM_W'(MAX_ITEMS)) begin
          // The array is too long: the element is dropped and flagged.
          ovf_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          ovf_d    = 1'b0;
          items_d  = items_q + 1'b1;
          prefix_d = prefix_q ^ val_q[WORD_BITS-1:0];
          key_d    = prefix_q ^ val_q[WORD_BITS-1:0];
          at_d     = '0;
          left_d   = LEFT_W'(WORD_BITS);
          state_d  = ST_WALK;
        end
      end

      // Follow existing branches of the insert path, one level per cycle.
      ST_WALK: begin
        if (child != '0) begin
          at_d   = child;
          left_d = left_q - 1'b1;
          if (left_q == LEFT_W'(1)) begin
            state_d = ST_QRY_RD;
          end
        end else if (store_full) begin
          state_d = ST_QRY_RD;
        end else begin
          // Hook a new node onto the current one and continue on fresh nodes.
          if (key_bit) begin
            wnode.kid_one = nodes_used_q;
          end else begin
            wnode.kid_zero = nodes_used_q;
          end
          ram_req.we    = 1'b1;
          ram_req.wdata = wnode;
          at_d          = nodes_used_q;
          nodes_used_d  = nodes_used_q + 1'b1;
          left_d        = left_q - 1'b1;
          state_d       = ST_FRESH;
        end
      end

      // A freshly allocated node is written whole: at most one child, which
      // is the next node to be allocated on the same path.
      ST_FRESH: begin
        ram_req.we = 1'b1;
        if ((left_q != '0) && !store_full) begin
          wnode = '0;
          if (key_bit) begin
            wnode.kid_one = nodes_used_q;
          end else begin
            wnode.kid_zero = nodes_used_q;
          end
          ram_req.wdata = wnode;
          at_d          = nodes_used_q;
          nodes_used_d  = nodes_used_q + 1'b1;
          left_d        = left_q - 1'b1;
        end else begin
          ram_req.wdata = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_PREP;
          end else begin
            state_d = ST_QRY_RD;
          end
        end
      end

      ST_QRY_RD: begin
        at_d    = '0;
        left_d  = LEFT_W'(WORD_BITS);
        acc_d   = '0;
        state_d = ST_QRY;
      end

      // Greedy walk: take the opposite bit wherever that branch exists.
      ST_QRY: begin
        if (flip != '0) begin
          at_d       = flip;
          cand[lvl]  = 1'b1;
          acc_d      = cand;
        end else if (same != '0) begin
          at_d = same;
        end
        left_d = left_q - 1'b1;
        if ((left_q == LEFT_W'(1)) || ((flip == '0) && (same == '0))) begin
          if (cand > best_q) begin
            best_d = cand;
          end
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.best_xor = best_q[31:0];
          out_d.overflow = ovf_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Writes use the current node; reads look one step ahead so that the
    // next level's node arrives in the following cycle.
    ram_req.addr = ram_req.we ? at_q : at_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      nodes_used_q <= '0;
      prefix_q     <= '0;
      best_q       <= '0;
      items_q      <= '0;
      init_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      nodes_used_q <= nodes_used_d;
      prefix_q     <= prefix_d;
      best_q       <= best_d;
      items_q      <= items_d;
      init_q       <= init_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    key_q  <= key_d;
    at_q   <= at_d;
    left_q <= left_d;
    acc_q  <= acc_d;
    ovf_q  <= ovf_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

FILE: src/mxst_node_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Trie node store
// Single-port synchronous memory of trie nodes with a registered read.
// ----------------------------------------------------------------------------
module mxst_node_ram (
  input  wire logic              clk_i,
  input  wire mxst_pkg::ram_req_t req_i,
  output      mxst_pkg::node_t    rdata_o
);
  import mxst_pkg::*;

  node_t mem [0:NODE_DEPTH-1];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: bench/max_xor_subarray_trie_checker.sv
// ----------------------------------------------------------------------------
// Maximum XOR subarray checker
// Watches both channels of the block. It predicts the best subarray XOR for
// every input transfer and compares each output transfer with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie_checker
  import mxst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_data_i,
  output int             error_count_o,
  output int             awaiting_o
);

  // Every prefix XOR of the current array, the empty prefix included. The
  // best XOR for a new prefix is its largest XOR with any of these.
  logic [31:0] prefix_seen[$];
  logic [31:0] prefix_acc;
  logic [31:0] best_acc;
  int unsigned taken;

  out_item_t   answer_fifo[$];
  out_item_t   wanted;
  out_item_t   fresh;
  int          errors;

  task automatic predict_best_xor(input in_item_t item, output out_item_t ans);
    logic [31:0] cand;
    if (item.start_new) begin
      prefix_seen.delete();
      prefix_acc = '0;
      best_acc   = '0;
      taken      = 0;
    end
    if (prefix_seen.size() == 0) begin
      prefix_seen.push_back('0);
    end
    ans.overflow = 1'b0;
    if (taken >= MAX_ITEMS) begin
      ans.overflow = 1'b1;
    end else begin
      taken++;
      prefix_acc = prefix_acc ^ item.value;
      prefix_seen.push_back(prefix_acc);
      foreach (prefix_seen[k]) begin
        cand = prefix_acc ^ prefix_seen[k];
        if (cand > best_acc) best_acc = cand;
      end
    end
    ans.best_xor = best_acc;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_seen.delete();
      answer_fifo.delete();
      prefix_acc    = '0;
      best_acc      = '0;
      taken         = 0;
      errors        = 0;
      error_count_o <= 0;
      awaiting_o    <= 0;
    end else begin
      // The result leaving now always belongs to an earlier transfer, so it
      // is matched before this cycle's input is predicted.
      if (out_valid_i && out_ready_i) begin
        if (answer_fifo.size() == 0) begin
          errors++;
          $error("unexpected result: best_xor %h overflow %b",
                 out_data_i.best_xor, out_data_i.overflow);
        end else begin
          wanted = answer_fifo.pop_front();
          if (out_data_i.best_xor !== wanted.best_xor) begin
            errors++;
            $error("best_xor: expected %h, got %h", wanted.best_xor, out_data_i.best_xor);
          end
          if (out_data_i.overflow !== wanted.overflow) begin
            errors++;
            $error("overflow: expected %b, got %b", wanted.overflow, out_data_i.overflow);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_best_xor(in_data_i, fresh);
        answer_fifo.push_back(fresh);
      end
      error_count_o <= errors;
      awaiting_o    <= answer_fifo.size();
    end
  end

endmodule

FILE: bench/max_xor_subarray_trie_test.sv
// ----------------------------------------------------------------------------
// Maximum XOR subarray testbench
// Drives arrays of 32-bit elements into the trie block with random idling on
// both channels, including one array long enough to hit the item limit, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module max_xor_subarray_trie_test;
  import mxst_pkg::*;

  // Nothing may be accepted for this many cycles in a correct run only far
  // beyond the worst case: a long receiver stall, then a long sender gap,
  // then the first element of an array with its zero path.
  localparam int QUIET_LIMIT  = 4000;
  // Cycles to watch for stray results once every expected one has arrived.
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 1500;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  int        error_count;
  int        awaiting;
  int        quiet_cycles = 0;
  // While calm is set neither side idles, so back-to-back transfers occur.
  logic      calm = 1'b0;

  always #5 clk_i = ~clk_i;

  max_xor_subarray_trie dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  max_xor_subarray_trie_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .error_count_o(error_count),
    .awaiting_o   (awaiting)
  );

  // Idle lengths: mostly none or short, now and then long enough to cover a
  // whole element's trie walk, so that gaps land on every phase of it.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 150);
  endfunction

  // Element patterns chosen to give the trie both dense and sparse shapes.
  // Repeating the previous element cancels it in the prefix, so prefixes
  // that are already stored come back.
  function automatic logic [31:0] pick_element(input logic [31:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4:          return $urandom_range(0, 15);
      5:          return 32'h1 << $urandom_range(0, 31);
      6:          return $urandom() & 32'hFF00_0000;
      7:          return prev;
      8:          return ~(32'h1 << $urandom_range(0, 31));
      default:    return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Offers one element and returns at the edge where it is transferred. Valid
  // is left high, so that a following element with no gap keeps it high
  // without dropping it within the same step.
  task automatic send_element(input logic [31:0] v, input logic first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    in_data_i.value     <= v;
    in_data_i.start_new <= first;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Receiver: ready is held for random stretches and dropped for random
  // stalls, independently of whether a result is waiting.
  initial begin
    int hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          sent;
    int          len;
    int          long_at;
    logic        long_done;
    logic [31:0] prev;
    logic [31:0] v;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The very first element carries no start flag, so it must
    // open an array on its own.
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    // Single top bit, then a low bit, then both, which returns the prefix to
    // zero, a value that is already in the trie.
    send_element(32'h8000_0000, 1'b1);
    send_element(32'h0000_0001, 1'b0);
    send_element(32'h8000_0001, 1'b0);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b0);
    // An array of zeros only: the best XOR stays zero.
    send_element(32'h0000_0000, 1'b1);
    send_element(32'h0000_0000, 1'b0);
    // Complementary halves give the full-scale maximum.
    send_element(32'h7FFF_FFFF, 1'b1);
    send_element(32'h8000_0000, 1'b0);
    // Rising one-hot elements, each of the first four a new branch at a higher bit.
    send_element(32'h0000_0001, 1'b1);
    send_element(32'h0000_0002, 1'b0);
    send_element(32'h0000_0004, 1'b0);
    send_element(32'h4000_0000, 1'b0);
    send_element(32'h0000_0004, 1'b0);
    // A one-element array right after another start.
    send_element(32'hFFFF_FFFE, 1'b1);
    send_element(32'hDEAD_BEEF, 1'b1);
    send_element(32'hDEAD_BEEF, 1'b0);
    send_element(32'h1234_5678, 1'b0);

    // Random part: arrays of random length, mostly short. One array runs a
    // few elements past the item limit, so the overflow result is seen and
    // the next start must clear it. Now and then an array opens without a
    // start flag and simply extends the one before.
    sent      = 0;
    long_done = 1'b0;
    long_at   = $urandom_range(50, 450);
    while (sent < RANDOM_ITEMS) begin
      if (!long_done && sent >= long_at) begin
        len       = MAX_ITEMS + $urandom_range(1, 6);
        long_done = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(13, 60);
      end else begin
        len = $urandom_range(1, 12);
      end
      calm = ($urandom_range(0, 3) == 0);
      prev = '0;
      for (int k = 0; k < len; k++) begin
        v = pick_element(prev);
        send_element(v, (k == 0) && ($urandom_range(0, 15) != 0));
        prev = v;
      end
      sent += len;
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // Let every expected result arrive, then watch a while for stray ones.
    while (awaiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
